// ===== rtl/core/keccak_f200_permutation_defines.svh =====
// Assertion macros shared by the Keccak-f[200] permutation RTL
`ifndef KECCAK_F200_PERMUTATION_DEFINES_SVH
`define KECCAK_F200_PERMUTATION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define KF200_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kf200_perm: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define KF200_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kf200_perm: next-cycle check failed");

`endif

// ===== rtl/core/kf200_pkg.sv =====
// Types, constants and lane helpers for the Keccak-f[200] permutation
`timescale 1ns / 1ps
package kf200_pkg;

  localparam int LANES       = 25;
  localparam int LANE_W      = 8;
  localparam int STATE_W     = LANES * LANE_W;
  localparam int FULL_ROUNDS = 18;
  localparam int ROUNDS_DEF  = 18;
  localparam int RC_IDX_W    = 5;

  // Lane x+5y sits at bits 8*(x+5y); matches the packed stream word
  typedef logic [LANES-1:0][LANE_W-1:0] state_t;

  function automatic logic [LANE_W-1:0] round_const(input logic [RC_IDX_W-1:0] idx);
    logic [LANE_W-1:0] rc;
    case (idx)
      5'd0:    rc = 8'h01;
      5'd1:    rc = 8'h82;
      5'd2:    rc = 8'h8A;
      5'd3:    rc = 8'h00;
      5'd4:    rc = 8'h8B;
      5'd5:    rc = 8'h01;
      5'd6:    rc = 8'h81;
      5'd7:    rc = 8'h09;
      5'd8:    rc = 8'h8A;
      5'd9:    rc = 8'h88;
      5'd10:   rc = 8'h09;
      5'd11:   rc = 8'h0A;
      5'd12:   rc = 8'h8B;
      5'd13:   rc = 8'h8B;
      5'd14:   rc = 8'h89;
      5'd15:   rc = 8'h03;
      5'd16:   rc = 8'h02;
      5'd17:   rc = 8'h80;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // Rho offsets reduced mod 8, indexed by x+5y
  function automatic logic [2:0] rho_off(input logic [4:0] lane);
    logic [2:0] off;
    case (lane)
      5'd0:    off = 3'd0;
      5'd1:    off = 3'd1;
      5'd2:    off = 3'd6;
      5'd3:    off = 3'd4;
      5'd4:    off = 3'd3;
      5'd5:    off = 3'd4;
      5'd6:    off = 3'd4;
      5'd7:    off = 3'd6;
      5'd8:    off = 3'd7;
      5'd9:    off = 3'd4;
      5'd10:   off = 3'd3;
      5'd11:   off = 3'd2;
      5'd12:   off = 3'd3;
      5'd13:   off = 3'd1;
      5'd14:   off = 3'd7;
      5'd15:   off = 3'd1;
      5'd16:   off = 3'd5;
      5'd17:   off = 3'd7;
      5'd18:   off = 3'd5;
      5'd19:   off = 3'd0;
      5'd20:   off = 3'd2;
      5'd21:   off = 3'd2;
      5'd22:   off = 3'd5;
      5'd23:   off = 3'd0;
      5'd24:   off = 3'd6;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  function automatic logic [LANE_W-1:0] rotl8(input logic [LANE_W-1:0] v,
                                              input logic [2:0] n);
    logic [2*LANE_W-1:0] t;
    t = {v, v} << n;
    return t[2*LANE_W-1:LANE_W];
  endfunction

endpackage

// ===== rtl/core/kf200_round.sv =====
// One Keccak-f[200] round: theta, rho, pi, chi and iota
`timescale 1ns / 1ps
module kf200_round
  import kf200_pkg::*;
(
  input  state_t            state_i,
  input  logic [LANE_W-1:0] rc_i,
  output state_t            state_o
);

  logic [4:0][LANE_W-1:0] col_par;
  logic [4:0][LANE_W-1:0] theta_d;
  state_t                 theta_st;
  state_t                 pi_st;
  state_t                 chi_st;

  always_comb begin
    for (int x = 0; x < 5; x++) begin
      col_par[x] = state_i[x] ^ state_i[x+5] ^ state_i[x+10] ^ state_i[x+15] ^ state_i[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      theta_d[x] = col_par[(x+4)%5] ^ rotl8(col_par[(x+1)%5], 3'd1);
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        theta_st[x+5*y] = state_i[x+5*y] ^ theta_d[x];
      end
    end
    // lane (x,y) moves to (y, 2x+3y) after its rotation
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        pi_st[y+5*((2*x+3*y)%5)] = rotl8(theta_st[x+5*y], rho_off(5'(x+5*y)));
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        chi_st[x+5*y] = pi_st[x+5*y] ^ (~pi_st[(x+1)%5+5*y] & pi_st[(x+2)%5+5*y]);
      end
    end
    state_o    = chi_st;
    state_o[0] = chi_st[0] ^ rc_i;
  end

endmodule

// ===== rtl/core/kf200_stage.sv =====
// Pipeline stage: one round followed by a stallable state register
`timescale 1ns / 1ps
module kf200_stage
  import kf200_pkg::*;
#(
  parameter int RC_IDX = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  state_t state_i,
  output logic   ready_o,
  output logic   valid_o,
  output state_t state_o,
  input  logic   ready_i
);

  localparam logic [LANE_W-1:0] Rc = round_const(RC_IDX_W'(RC_IDX));

  state_t round_d;
  state_t state_q;
  logic   valid_q;

  kf200_round u_round (
    .state_i (state_i),
    .rc_i    (Rc),
    .state_o (round_d)
  );

  // advance when empty or when the next stage takes the held request
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= round_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== rtl/core/keccak_f200_permutation.sv =====
// Keccak-f[200] permutation, one round per pipeline stage
//
//   port group   dir  width  contents
//   s_axis_*     in   200    state before the permutation
//   m_axis_*     out  200    state after the last ROUNDS rounds
//
// Takes one request per cycle unless m_axis_tready stalls the pipeline; one round per stage.
// The last stage register drives m_axis_* directly.
// A stalled stage holds its request; empty stages ahead of it still fill.
// rst_ni clears the stage valid bits only; state registers are not reset.
`timescale 1ns / 1ps
`include "keccak_f200_permutation_defines.svh"
module keccak_f200_permutation
  import kf200_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [63:0] state_in_w0, [127:64] state_in_w1, [191:128] state_in_w2,
  // [199:192] state_in_w3
  input  logic [STATE_W-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [63:0] state_out_w0, [127:64] state_out_w1, [191:128] state_out_w2,
  // [199:192] state_out_w3
  output logic [STATE_W-1:0] m_axis_tdata
);

  // index k is the link into stage k; index ROUNDS is the output port
  logic   stg_valid [ROUNDS+1];
  logic   stg_ready [ROUNDS+1];
  state_t stg_state [ROUNDS+1];

  assign stg_valid[0]      = s_axis_tvalid;
  assign stg_state[0]      = state_t'(s_axis_tdata);
  assign s_axis_tready     = stg_ready[0];
  assign stg_ready[ROUNDS] = m_axis_tready;
  assign m_axis_tvalid     = stg_valid[ROUNDS];
  assign m_axis_tdata      = STATE_W'(stg_state[ROUNDS]);

  for (genvar k = 0; k < ROUNDS; k++) begin : g_stage
    kf200_stage #(
      .RC_IDX (FULL_ROUNDS - ROUNDS + k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .state_i (stg_state[k]),
      .ready_o (stg_ready[k]),
      .valid_o (stg_valid[k+1]),
      .state_o (stg_state[k+1]),
      .ready_i (stg_ready[k+1])
    );
  end

  `KF200_ASSERT_IMPL(a_empty_out_ready, !m_axis_tvalid, s_axis_tready)
  `KF200_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, stg_valid[1])
  `KF200_ASSERT_NEXT(a_stall_holds, stg_valid[1] && !stg_ready[1], stg_valid[1] && $stable(stg_state[1]))

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Keccak-f[200] pipelined permutation
`timescale 1ns / 1ps
module tb
  import kf200_pkg::*;
();

  localparam int ROUND_CNT   = 18;
  localparam int RAND_ITEMS  = 475;
  localparam int CYCLE_LIMIT = 400000;

  // Round constants, index 0 in the lowest byte
  localparam logic [FULL_ROUNDS-1:0][7:0] RC_TAB = {
    8'h80, 8'h02, 8'h03, 8'h89, 8'h8B, 8'h8B, 8'h0A, 8'h09, 8'h88,
    8'h8A, 8'h09, 8'h81, 8'h01, 8'h8B, 8'h00, 8'h8A, 8'h82, 8'h01
  };
  // Rho offsets mod 8 per lane x+5y, lane 0 in the lowest entry
  localparam logic [LANES-1:0][2:0] RHO_TAB = {
    3'd6, 3'd0, 3'd5, 3'd2, 3'd2, 3'd0, 3'd5, 3'd7, 3'd5, 3'd1,
    3'd7, 3'd1, 3'd3, 3'd2, 3'd3, 3'd4, 3'd7, 3'd6, 3'd4, 3'd4,
    3'd3, 3'd4, 3'd6, 3'd1, 3'd0
  };

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [STATE_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [STATE_W-1:0] m_axis_tdata;

  state_t exp_states[$];
  state_t directed_rows[$];
  int     mismatch_cnt = 0;
  int     cycle_cnt = 0;
  int     idle_pct;
  int     stall_pct;

  keccak_f200_permutation #(
    .ROUNDS(ROUND_CNT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] rot_left(input logic [7:0] v, input int n);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = v << n;
    lo = v >> (8 - n);
    return hi | lo;
  endfunction

  // Apply the last ROUND_CNT rounds of the permutation
  function automatic state_t permute_state(input state_t st);
    logic [7:0] a [LANES];
    logic [7:0] b [LANES];
    logic [7:0] c [5];
    logic [7:0] d [5];
    state_t     res;
    int         r;
    int         x;
    int         y;
    int         first;
    for (x = 0; x < LANES; x++) a[x] = st[x];
    first = (ROUND_CNT >= FULL_ROUNDS) ? 0 : FULL_ROUNDS - ROUND_CNT;
    for (r = first; r < FULL_ROUNDS; r++) begin
      for (x = 0; x < 5; x++) c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
      for (x = 0; x < 5; x++) d[x] = c[(x+4)%5] ^ rot_left(c[(x+1)%5], 1);
      for (y = 0; y < 5; y++)
        for (x = 0; x < 5; x++) a[x+5*y] = a[x+5*y] ^ d[x];
      for (y = 0; y < 5; y++)
        for (x = 0; x < 5; x++)
          b[y + 5*((2*x + 3*y) % 5)] = rot_left(a[x+5*y], int'(RHO_TAB[x+5*y]));
      for (y = 0; y < 5; y++)
        for (x = 0; x < 5; x++)
          a[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
      a[0] = a[0] ^ RC_TAB[r];
    end
    for (x = 0; x < LANES; x++) res[x] = a[x];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Drive one request; entered and left at a falling edge
  task automatic send_state(input state_t st);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_states.push_back(permute_state(st));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    logic [STATE_W-1:0] exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_states.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        exp_v = exp_states.pop_front();
        check_field("state_out_w0", exp_v[63:0],    m_axis_tdata[63:0]);
        check_field("state_out_w1", exp_v[127:64],  m_axis_tdata[127:64]);
        check_field("state_out_w2", exp_v[191:128], m_axis_tdata[191:128]);
        check_field("state_out_w3", {56'h0, exp_v[199:192]},
                    {56'h0, m_axis_tdata[199:192]});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    state_t st;
    int     phase;
    int     n;
    int     k;
    int     bit_idx;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;

    directed_rows.push_back('0);
    directed_rows.push_back('1);
    directed_rows.push_back(200'h01);
    directed_rows.push_back({8'h80, 192'h0});
    directed_rows.push_back({1'b1, 199'h0});
    directed_rows.push_back({{199{1'b1}}, 1'b0});
    directed_rows.push_back({25{8'hAA}});
    directed_rows.push_back({25{8'h55}});
    directed_rows.push_back({25{8'h01}});
    directed_rows.push_back({25{8'h80}});
    directed_rows.push_back({136'h0, 64'hFFFF_FFFF_FFFF_FFFF});
    directed_rows.push_back({72'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
    directed_rows.push_back({8'h0, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0});
    directed_rows.push_back({8'hFF, 192'h0});
    directed_rows.push_back({96'h0, 8'hFF, 96'h0});
    for (k = 0; k < LANES; k++) st[k] = 8'(k);
    directed_rows.push_back(st);
    for (k = 0; k < LANES; k++) st[k] = 8'(8'hFF - k);
    directed_rows.push_back(st);
    directed_rows.push_back({25{8'h0F}});
    directed_rows.push_back({25{8'hF0}});

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_state(directed_rows[i]);

    for (phase = 0; phase < 4; phase++) begin
      // hold off until the pipeline has drained
      s_axis_tvalid <= 1'b0;
      wait (exp_states.size() == 0);
      @(negedge clk_i);
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (n = 0; n < RAND_ITEMS; n++) begin
        case ($urandom_range(3))
          0: begin
            for (k = 0; k < LANES; k++) st[k] = 8'($urandom);
          end
          1: begin
            bit_idx = $urandom_range(STATE_W - 1);
            st = '0;
            st[bit_idx/8][bit_idx%8] = 1'b1;
          end
          2: begin
            bit_idx = $urandom_range(STATE_W - 1);
            st = '1;
            st[bit_idx/8][bit_idx%8] = 1'b0;
          end
          default: begin
            for (k = 0; k < LANES; k++) begin
              case ($urandom_range(2))
                0:       st[k] = 8'h00;
                1:       st[k] = 8'hFF;
                default: st[k] = 8'($urandom);
              endcase
            end
          end
        endcase
        send_state(st);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (exp_states.size() == 0);
    repeat (ROUND_CNT + 8) @(posedge clk_i);
    if (exp_states.size() != 0) begin
      $display("%0t: results outstanding, expected 0, actual %0d", $time,
               exp_states.size());
    end
    if (mismatch_cnt == 0 && exp_states.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== keccak_f200_permutation.f =====
+incdir+rtl/core
rtl/core/kf200_pkg.sv
rtl/core/kf200_round.sv
rtl/core/kf200_stage.sv
rtl/core/keccak_f200_permutation.sv
verif/tb.sv
